// ----- rtl/jtw_pkg.sv -----
// Package with the TAP state codes, transition tables and microcode types of the state walker.
`timescale 1ns / 1ps

package jtw_pkg;

  // TAP state codes in standard order, plus the unknown code.
  localparam logic [4:0] ST_TLR     = 5'd0;
  localparam logic [4:0] ST_SHDR    = 5'd4;
  localparam logic [4:0] ST_SHIR    = 5'd11;
  localparam logic [4:0] ST_UNKNOWN = 5'd16;

  // Command opcodes.
  localparam logic [1:0] OP_GOTO       = 2'd0;
  localparam logic [1:0] OP_RESET      = 2'd1;
  localparam logic [1:0] OP_SHIFT_EXIT = 2'd2;

  // Limits.
  localparam logic [5:0] MAX_EXTRA_ZEROS = 6'd48;
  localparam logic [5:0] RESULT_LIMIT    = 6'd60;
  localparam logic [2:0] RESET_ONES_LEFT = 3'd4;

  // Microprogram entry points and steps.
  localparam logic [2:0] PC_G_ONES = 3'd0;
  localparam logic [2:0] PC_G_XONE = 3'd1;
  localparam logic [2:0] PC_WALK   = 3'd2;
  localparam logic [2:0] PC_ZERO   = 3'd3;
  localparam logic [2:0] PC_R_ONES = 3'd4;
  localparam logic [2:0] PC_B_ONES = 3'd5;
  localparam logic [2:0] PC_SHX    = 3'd6;

  // Control word fields.
  typedef enum logic [1:0] {GD_ALWAYS, GD_NOT_AT_TGT, GD_ZEROS_NZ} guard_t;
  typedef enum logic [1:0] {TS_ZERO, TS_ONE, TS_ROUTE} tms_sel_t;
  typedef enum logic [2:0] {SO_HOLD, SO_ADV, SO_RST5, SO_TLR, SO_SHEXIT} st_op_t;
  typedef enum logic [1:0] {LS_NONE, LS_CNT_Z, LS_WALK_END, LS_ZEROS_ONE} last_sel_t;
  typedef enum logic [1:0] {CD_ALWAYS, CD_CNT_Z, CD_NXT_AT_TGT, CD_ZEROS_LE1} cond_t;
  typedef enum logic [1:0] {AC_NEXT, AC_STAY, AC_END} act_t;

  typedef struct packed {
    guard_t    guard;
    logic      emit;
    tms_sel_t  tms_sel;
    st_op_t    st_op;
    logic      cnt_dec;
    logic      zeros_dec;
    logic      bad;
    last_sel_t last_sel;
    cond_t     cond;
    act_t      on_true;
    act_t      on_false;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic unknown;
    logic in_shift;
    logic cond_true;
    logic stall;
  } dp_stat_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic busy;
    logic start;
    logic fire;
  } seq_ctl_t;

  // Standard TAP transition; the unknown state stays unknown.
  function automatic logic [4:0] tap_next(logic [4:0] s, logic tms);
    logic [4:0] n;
    unique case (s)
      5'd0:    n = tms ? 5'd0  : 5'd1;
      5'd1:    n = tms ? 5'd2  : 5'd1;
      5'd2:    n = tms ? 5'd9  : 5'd3;
      5'd3:    n = tms ? 5'd5  : 5'd4;
      5'd4:    n = tms ? 5'd5  : 5'd4;
      5'd5:    n = tms ? 5'd8  : 5'd6;
      5'd6:    n = tms ? 5'd7  : 5'd6;
      5'd7:    n = tms ? 5'd8  : 5'd4;
      5'd8:    n = tms ? 5'd2  : 5'd1;
      5'd9:    n = tms ? 5'd0  : 5'd10;
      5'd10:   n = tms ? 5'd12 : 5'd11;
      5'd11:   n = tms ? 5'd12 : 5'd11;
      5'd12:   n = tms ? 5'd15 : 5'd13;
      5'd13:   n = tms ? 5'd14 : 5'd13;
      5'd14:   n = tms ? 5'd15 : 5'd11;
      5'd15:   n = tms ? 5'd2  : 5'd1;
      default: n = ST_UNKNOWN;
    endcase
    return n;
  endfunction

  // TMS bit that moves the current state one step along the routing to the target.
  function automatic logic route_tms(logic [4:0] cur, logic [3:0] tgt);
    logic t;
    case (cur)
      5'd0:    t = 1'b0;
      5'd2:    t = !(tgt >= 4'd3 && tgt <= 4'd8);
      5'd3:    t = (tgt != 4'd4);
      5'd5:    t = !(tgt >= 4'd4 && tgt <= 4'd7);
      5'd7:    t = !(tgt >= 4'd4 && tgt <= 4'd6);
      5'd8:    t = (tgt != 4'd1);
      5'd9:    t = !(tgt >= 4'd10);
      5'd10:   t = (tgt != 4'd11);
      5'd12:   t = !(tgt >= 4'd11 && tgt <= 4'd14);
      5'd14:   t = !(tgt >= 4'd11 && tgt <= 4'd13);
      5'd15:   t = (tgt != 4'd1);
      default: t = 1'b1;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/jtw_if.sv -----
// Valid/ready channel interfaces for command items and TMS result items.
`timescale 1ns / 1ps

interface jtw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] target_state;
  logic [5:0] extra_zeros;
  logic       shift_tms;

  modport source (output valid, output opcode, output target_state, output extra_zeros,
                  output shift_tms, input ready);
  modport sink (input valid, input opcode, input target_state, input extra_zeros,
                input shift_tms, output ready);
endinterface

interface jtw_out_if;
  logic       valid;
  logic       ready;
  logic       tms_bit;
  logic [4:0] state_after;
  logic       bad_state;
  logic       last_bit;

  modport source (output valid, output tms_bit, output state_after, output bad_state,
                  output last_bit, input ready);
  modport sink (input valid, input tms_bit, input state_after, input bad_state,
                input last_bit, output ready);
endinterface

// ----- rtl/jtw_ucode_rom.sv -----
// Microcode table: one control word per program step.
`timescale 1ns / 1ps

module jtw_ucode_rom
  import jtw_pkg::*;
(
  input  logic [2:0] pc,
  output ctrl_t      ctrl
);

  // Program: goto reset ones, extra one, route walk, extra zeros; reset ones; bad-state ones; shift exit step.
  always_comb begin
    unique case (pc)
      PC_G_ONES: ctrl = '{GD_ALWAYS, 1'b1, TS_ONE, SO_RST5, 1'b1, 1'b0, 1'b0,
                          LS_NONE, CD_CNT_Z, AC_NEXT, AC_STAY};
      PC_G_XONE: ctrl = '{GD_ALWAYS, 1'b1, TS_ONE, SO_TLR, 1'b0, 1'b0, 1'b0,
                          LS_WALK_END, CD_ALWAYS, AC_NEXT, AC_NEXT};
      PC_WALK:   ctrl = '{GD_NOT_AT_TGT, 1'b1, TS_ROUTE, SO_ADV, 1'b0, 1'b0, 1'b0,
                          LS_WALK_END, CD_NXT_AT_TGT, AC_NEXT, AC_STAY};
      PC_ZERO:   ctrl = '{GD_ZEROS_NZ, 1'b1, TS_ZERO, SO_ADV, 1'b0, 1'b1, 1'b0,
                          LS_ZEROS_ONE, CD_ZEROS_LE1, AC_END, AC_STAY};
      PC_R_ONES: ctrl = '{GD_ALWAYS, 1'b1, TS_ONE, SO_RST5, 1'b1, 1'b0, 1'b0,
                          LS_CNT_Z, CD_CNT_Z, AC_END, AC_STAY};
      PC_B_ONES: ctrl = '{GD_ALWAYS, 1'b1, TS_ONE, SO_RST5, 1'b1, 1'b0, 1'b1,
                          LS_CNT_Z, CD_CNT_Z, AC_END, AC_STAY};
      PC_SHX:    ctrl = '{GD_ALWAYS, 1'b0, TS_ZERO, SO_SHEXIT, 1'b0, 1'b0, 1'b0,
                          LS_NONE, CD_ALWAYS, AC_END, AC_END};
      default:   ctrl = '{GD_ALWAYS, 1'b0, TS_ZERO, SO_HOLD, 1'b0, 1'b0, 1'b0,
                          LS_NONE, CD_ALWAYS, AC_END, AC_END};
    endcase
  end

endmodule

// ----- rtl/jtw_sequencer.sv -----
// Step counter with command dispatch and conditional branching over the microprogram.
`timescale 1ns / 1ps

module jtw_sequencer
  import jtw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  input  ctrl_t      ctrl,
  input  dp_stat_t   stat,
  output logic [2:0] pc,
  output seq_ctl_t   seq
);

  logic       busy_r, busy_nxt;
  logic [2:0] pc_r, pc_nxt;
  logic       start;
  logic       fire;
  act_t       act;

  assign start = in_valid && !busy_r;
  assign fire  = busy_r && !stat.stall;
  assign act   = stat.cond_true ? ctrl.on_true : ctrl.on_false;

  // Dispatch a new command or advance the program by the branch of the current step.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      case (in_opcode)
        OP_GOTO:       pc_nxt = stat.unknown ? PC_G_ONES : PC_WALK;
        OP_RESET:      pc_nxt = PC_R_ONES;
        OP_SHIFT_EXIT: pc_nxt = stat.in_shift ? PC_SHX : PC_B_ONES;
        default:       busy_nxt = 1'b0;
      endcase
    end else if (fire) begin
      unique case (act)
        AC_NEXT: pc_nxt = pc_r + 3'd1;
        AC_STAY: pc_nxt = pc_r;
        AC_END:  busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_G_ONES;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign pc  = pc_r;
  assign seq = '{busy: busy_r, start: start, fire: fire};

  // A shift exit from a shift state runs the single exit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && in_opcode == OP_SHIFT_EXIT && stat.in_shift |=> busy_r && pc_r == PC_SHX)
    else $error("shift exit did not dispatch to the exit step");

  // The step counter never leaves the program while busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= PC_SHX)
    else $error("step counter outside the program");

  // A new command is only taken when the previous one has ended.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !(fire && act == AC_END) |=> busy_r)
    else $error("command ended without an end step");

endmodule

// ----- rtl/jtw_datapath.sv -----
// TAP state model, bit counters and registered result stage driven by the control word.
`timescale 1ns / 1ps

module jtw_datapath
  import jtw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      ctrl,
  input  seq_ctl_t   seq,
  input  logic [3:0] in_target_state,
  input  logic [5:0] in_extra_zeros,
  input  logic       in_shift_tms,
  input  logic       out_ready,
  output dp_stat_t   stat,
  output logic       out_valid,
  output logic       out_tms_bit,
  output logic [4:0] out_state_after,
  output logic       out_bad_state,
  output logic       out_last_bit
);

  logic [4:0] tap_state_r;
  logic [3:0] target_r;
  logic       stms_r;
  logic [2:0] cnt_r;
  logic [5:0] zeros_r;
  logic [5:0] ecnt_r;
  logic       out_valid_r;
  logic       tms_r;
  logic [4:0] st_out_r;
  logic       bad_r;
  logic       last_r;

  logic       at_tgt;
  logic       guard_ok;
  logic       tms;
  logic [4:0] st_step;
  logic [4:0] st_raw;
  logic [4:0] st_nxt;
  logic       cond_true;
  logic       last_c;
  logic       report;
  logic       slot_free;

  // Guard, TMS choice and next state for the current step.
  always_comb begin
    at_tgt = (tap_state_r == {1'b0, target_r});
    case (ctrl.guard)
      GD_ALWAYS:     guard_ok = 1'b1;
      GD_NOT_AT_TGT: guard_ok = !at_tgt;
      GD_ZEROS_NZ:   guard_ok = (zeros_r != 6'd0);
      default:       guard_ok = 1'b0;
    endcase
    case (ctrl.tms_sel)
      TS_ZERO:  tms = 1'b0;
      TS_ONE:   tms = 1'b1;
      TS_ROUTE: tms = route_tms(tap_state_r, target_r);
      default:  tms = 1'b1;
    endcase
    st_step = tap_next(tap_state_r, tms);
    case (ctrl.st_op)
      SO_HOLD:   st_raw = tap_state_r;
      SO_ADV:    st_raw = st_step;
      SO_RST5:   st_raw = (cnt_r == 3'd0) ? ST_TLR : st_step;
      SO_TLR:    st_raw = ST_TLR;
      SO_SHEXIT: st_raw = stms_r ? tap_state_r + 5'd1 : tap_state_r;
      default:   st_raw = tap_state_r;
    endcase
    st_nxt = guard_ok ? st_raw : tap_state_r;
  end

  // Branch condition and final-bit test, on counter values before the step and the state after it.
  always_comb begin
    case (ctrl.cond)
      CD_ALWAYS:     cond_true = 1'b1;
      CD_CNT_Z:      cond_true = (cnt_r == 3'd0);
      CD_NXT_AT_TGT: cond_true = (st_nxt == {1'b0, target_r});
      CD_ZEROS_LE1:  cond_true = (zeros_r <= 6'd1);
      default:       cond_true = 1'b1;
    endcase
    case (ctrl.last_sel)
      LS_NONE:      last_c = 1'b0;
      LS_CNT_Z:     last_c = (cnt_r == 3'd0);
      LS_WALK_END:  last_c = (st_nxt == {1'b0, target_r}) && (zeros_r == 6'd0);
      LS_ZEROS_ONE: last_c = (zeros_r == 6'd1);
      default:      last_c = 1'b0;
    endcase
  end

  // An emitted bit is reported while the result count is under the limit.
  assign report    = seq.busy && ctrl.emit && guard_ok && (ecnt_r < RESULT_LIMIT);
  assign slot_free = !out_valid_r || out_ready;

  assign stat = '{unknown:   (tap_state_r >= ST_UNKNOWN),
                  in_shift:  (tap_state_r == ST_SHDR) || (tap_state_r == ST_SHIR),
                  cond_true: cond_true,
                  stall:     report && !slot_free};

  // Control registers: state model, counters and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_state_r <= ST_UNKNOWN;
      cnt_r       <= 3'd0;
      zeros_r     <= 6'd0;
      ecnt_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (seq.start) begin
        cnt_r   <= RESET_ONES_LEFT;
        zeros_r <= (in_extra_zeros > MAX_EXTRA_ZEROS) ? MAX_EXTRA_ZEROS : in_extra_zeros;
        ecnt_r  <= 6'd0;
      end else if (seq.fire) begin
        tap_state_r <= st_nxt;
        if (guard_ok && ctrl.cnt_dec) begin
          cnt_r <= cnt_r - 3'd1;
        end
        if (guard_ok && ctrl.zeros_dec) begin
          zeros_r <= zeros_r - 6'd1;
        end
        if (report) begin
          ecnt_r <= ecnt_r + 6'd1;
        end
      end
      if (seq.fire && report) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command operands and result payload.
  always_ff @(posedge clk) begin
    if (seq.start) begin
      target_r <= in_target_state;
      stms_r   <= in_shift_tms;
    end
    if (seq.fire && report) begin
      tms_r    <= tms;
      st_out_r <= st_nxt;
      bad_r    <= ctrl.bad;
      last_r   <= last_c || (ecnt_r == RESULT_LIMIT - 6'd1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tms_bit     = tms_r;
  assign out_state_after = st_out_r;
  assign out_bad_state   = bad_r;
  assign out_last_bit    = last_r;

  // The state model only ever holds a TAP state or the unknown code.
  assert property (@(posedge clk) disable iff (!rst_n) tap_state_r <= ST_UNKNOWN)
    else $error("state model out of range");

  // The result count never passes the per-command limit.
  assert property (@(posedge clk) disable iff (!rst_n) ecnt_r <= RESULT_LIMIT)
    else $error("result count beyond limit");

  // The route walk runs only from a known state.
  assert property (@(posedge clk) disable iff (!rst_n)
    seq.fire && ctrl.tms_sel == TS_ROUTE |-> tap_state_r < ST_UNKNOWN)
    else $error("route walk from unknown state");

  // The extra zero count stays saturated.
  assert property (@(posedge clk) disable iff (!rst_n) zeros_r <= MAX_EXTRA_ZEROS)
    else $error("extra zero count above saturation");

endmodule

// ----- rtl/jtag_tap_state_walker.sv -----
// Top level of the JTAG TAP state walker: channels, sequencer, microcode table and datapath.
`timescale 1ns / 1ps

// Each command item is turned into a stream of TMS result items, one per clock while the
// result side takes them. A microcoded sequencer steps one control word per clock unless
// the result side stalls it: reset sends the reset ones; shift exit moves on from a shift
// state without a result, else sends the reset ones marked bad; goto from a known state
// sends the walk bits and extra zeros, the walk or zero step still running without a result
// when either is empty; goto from the unknown state first sends the reset ones and the extra
// one. Extra zeros saturate at 48, and at most 60 results are reported per command. A new
// command is taken the cycle after the previous one ends, even while its final result still
// waits in the output register. After reset the modelled TAP state is unknown (code 16).
module jtag_tap_state_walker
  import jtw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  jtw_in_if.sink    in_ch,
  jtw_out_if.source out_ch
);

  logic [2:0] pc;
  ctrl_t      ctrl;
  dp_stat_t   stat;
  seq_ctl_t   seq;

  assign in_ch.ready = !seq.busy;

  // Control program lookup.
  jtw_ucode_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  // Step counter and dispatch.
  jtw_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .ctrl      (ctrl),
    .stat      (stat),
    .pc        (pc),
    .seq       (seq)
  );

  // State model and result stage.
  jtw_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .seq             (seq),
    .in_target_state (in_ch.target_state),
    .in_extra_zeros  (in_ch.extra_zeros),
    .in_shift_tms    (in_ch.shift_tms),
    .out_ready       (out_ch.ready),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_tms_bit     (out_ch.tms_bit),
    .out_state_after (out_ch.state_after),
    .out_bad_state   (out_ch.bad_state),
    .out_last_bit    (out_ch.last_bit)
  );

endmodule
